[hw/rtl/mmau_pkg.sv]
// Shared types and constants of the memory access unit.
// Command codes, address map, decoded access and result records.
// No dependencies.
package mmau_pkg;

  // Default store depths in 32-bit words
  localparam int DATA_WORDS_DEF = 4096;
  localparam int CODE_WORDS_DEF = 4096;

  // Word offset widths inside the data and code regions
  localparam int DATA_OFS_W = 24;
  localparam int CODE_OFS_W = 22;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_FETCH  = 4'd0;
  localparam cmd_t CMD_LW     = 4'd1;
  localparam cmd_t CMD_LH     = 4'd2;
  localparam cmd_t CMD_LHU    = 4'd3;
  localparam cmd_t CMD_LB     = 4'd4;
  localparam cmd_t CMD_LBU    = 4'd5;
  localparam cmd_t CMD_SW     = 4'd6;
  localparam cmd_t CMD_SH     = 4'd7;
  localparam cmd_t CMD_SB     = 4'd8;
  localparam cmd_t CMD_LOADER = 4'd9;

  // Address map: code 0x10000000..0x10FFFFFF, data 0x20000000..0x23FFFFFF
  localparam logic [7:0]  CODE_REGION = 8'h10;
  localparam logic [5:0]  DATA_REGION = 6'h08;
  localparam logic [31:0] GETC_ADDR   = 32'h3000_0000;
  localparam logic [31:0] PUTC_ADDR   = 32'h3000_0004;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'b00,
    SZ_HALF = 2'b01,
    SZ_WORD = 2'b10
  } size_t;

  // Decoded access; all action flags are already gated by err
  typedef struct packed {
    logic       err;
    logic       code_rd;
    logic       code_wr;
    logic       data_rd;
    logic       data_wr;
    logic       getc;
    logic       putc;
    logic       rd_out;
    size_t      size;
    logic       sign_ext;
    logic [1:0] lane;
  } acc_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        getc_taken;
    logic        putc_valid;
    logic [7:0]  putc_char;
  } result_t;

endpackage

[hw/rtl/mmau_if.sv]
// Valid/ready channel interfaces of the memory access unit.
// Depends on mmau_pkg for the command type.
interface mmau_in_if;
  import mmau_pkg::*;
  logic        valid;
  logic        ready;
  cmd_t        cmd;
  logic [31:0] address;
  logic [31:0] store_data;
  logic [7:0]  getc_char;

  modport source (output valid, cmd, address, store_data, getc_char, input ready);
  modport sink   (input valid, cmd, address, store_data, getc_char, output ready);
endinterface

interface mmau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        access_error;
  logic        getc_taken;
  logic        putc_valid;
  logic [7:0]  putc_char;

  modport source (output valid, read_data, access_error, getc_taken, putc_valid,
                  putc_char, input ready);
  modport sink   (input valid, read_data, access_error, getc_taken, putc_valid,
                  putc_char, output ready);
endinterface

[hw/rtl/mmau_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mmau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mmau_wrap.sv]
// Word index reduction modulo the store depth.
// Power-of-two depths are masked; others use a reciprocal multiply, then a multiply-back and subtract.
// No package dependencies.
module mmau_wrap #(
  parameter int MODULUS = 4096,
  parameter int OFS_W   = 24,
  localparam int IW = (MODULUS > 1) ? $clog2(MODULUS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [OFS_W-1:0] ofs,
  output logic             done,
  output logic [IW-1:0]    rem
);

  localparam bit IS_POW2 = (MODULUS & (MODULUS - 1)) == 0;

  logic             ready_r;
  logic [OFS_W-1:0] ofs_r;

  generate
    if (IS_POW2) begin : g_mask
      // Capture offset; remainder is the low bits
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ready_r <= 1'b0;
        end else if (start) begin
          ready_r <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          ofs_r <= ofs;
        end
      end

      assign rem  = IW'(ofs_r & OFS_W'(MODULUS - 1));
      assign done = ready_r;
    end else begin : g_recip
      // Scaled reciprocal: the quotient estimate is exact or one low
      localparam int DW    = OFS_W + IW;
      localparam int SHIFT = OFS_W + IW;
      localparam int RW    = OFS_W + 1;
      localparam int PW    = OFS_W + RW;
      localparam logic [RW-1:0] RECIP = RW'((64'd1 << SHIFT) / 64'(MODULUS));

      logic [1:0]       stage_r;
      logic [OFS_W-1:0] quot_r;
      logic [IW:0]      part_r;
      logic [PW-1:0]    prod;
      logic [DW-1:0]    back;
      logic [DW-1:0]    raw;

      // Quotient estimate, then multiply back and subtract
      always_comb begin
        prod = {{RW{1'b0}}, ofs_r} * {{OFS_W{1'b0}}, RECIP};
        back = DW'(quot_r) * DW'(MODULUS);
        raw  = DW'(ofs_r) - back;
      end

      // Stage sequencing: capture, quotient, partial remainder
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stage_r <= 2'b00;
          ready_r <= 1'b0;
        end else if (start) begin
          stage_r <= 2'b01;
          ready_r <= 1'b0;
        end else if (stage_r[0]) begin
          stage_r <= 2'b10;
        end else if (stage_r[1]) begin
          stage_r <= 2'b00;
          ready_r <= 1'b1;
        end
      end

      // Advance the datapath registers
      always_ff @(posedge clk) begin
        if (start) begin
          ofs_r <= ofs;
        end
        if (stage_r[0]) begin
          quot_r <= OFS_W'(prod >> SHIFT);
        end
        if (stage_r[1]) begin
          part_r <= raw[IW:0];
        end
      end

      // Final correction: subtract the modulus once where the estimate was low
      assign rem  = (part_r >= (IW + 1)'(MODULUS)) ? IW'(part_r - (IW + 1)'(MODULUS))
                                                   : part_r[IW-1:0];
      assign done = ready_r;
    end
  endgenerate

endmodule

[hw/rtl/mmau_decode.sv]
// Command and address decode: size, region, port hits, alignment and error.
// Depends on mmau_pkg.
module mmau_decode (
  input  mmau_pkg::cmd_t  cmd,
  input  logic [31:0]     address,
  output mmau_pkg::acc_t  acc
);
  import mmau_pkg::*;

  size_t size;
  logic  is_fetch, is_loader, is_load, is_store;
  logic  bad_cmd, misalign, in_code, in_data, getc_hit, putc_hit, err;

  // Classify the command
  always_comb begin
    case (cmd) inside
      CMD_FETCH, CMD_LW, CMD_SW: size = SZ_WORD;
      CMD_LH, CMD_LHU, CMD_SH:   size = SZ_HALF;
      default:                   size = SZ_BYTE;
    endcase
    is_fetch  = cmd == CMD_FETCH;
    is_loader = cmd == CMD_LOADER;
    is_load   = cmd inside {[CMD_LW:CMD_LBU]};
    is_store  = cmd inside {CMD_SW, CMD_SH, CMD_SB};
    bad_cmd   = cmd > CMD_LOADER;
  end

  // Region, port and alignment checks
  always_comb begin
    in_code  = address[31:24] == CODE_REGION;
    in_data  = address[31:26] == DATA_REGION;
    getc_hit = address[31:2] == GETC_ADDR[31:2];
    putc_hit = address[31:2] == PUTC_ADDR[31:2];
    misalign = (size == SZ_WORD && address[1:0] != 2'b00) ||
               (size == SZ_HALF && address[0]);
    err = bad_cmd || misalign ||
          ((is_fetch || is_loader) && !in_code) ||
          (is_load && !getc_hit && !in_data) ||
          (is_store && !putc_hit && !in_data);
  end

  // Build the access record
  always_comb begin
    acc.err      = err;
    acc.code_rd  = !err && (is_fetch || is_loader);
    acc.code_wr  = !err && is_loader;
    acc.data_rd  = !err && ((is_load && !getc_hit) || (is_store && !putc_hit));
    acc.data_wr  = !err && is_store && !putc_hit;
    acc.getc     = !err && is_load && getc_hit;
    acc.putc     = !err && is_store && putc_hit;
    acc.rd_out   = !err && (is_fetch || (is_load && !getc_hit));
    acc.size     = size;
    acc.sign_ext = cmd == CMD_LH || cmd == CMD_LB;
    acc.lane     = address[1:0];
  end

endmodule

[hw/rtl/mmau_exec.sv]
// Lane extract with extension, lane merge for stores, and result assembly.
// Depends on mmau_pkg.
module mmau_exec (
  input  mmau_pkg::acc_t    acc,
  input  logic [31:0]       word,
  input  logic [31:0]       store_data,
  input  logic [7:0]        getc_char,
  output mmau_pkg::result_t res,
  output logic [31:0]       wr_word
);
  import mmau_pkg::*;

  logic [4:0]  sh_b, sh_h;
  logic [7:0]  byte_v;
  logic [15:0] half_v;
  logic [31:0] load_v, mask, ins;

  // Big-endian lane positions
  always_comb begin
    sh_b   = {~acc.lane, 3'b000};
    sh_h   = {~acc.lane[1], 4'b0000};
    byte_v = 8'(word >> sh_b);
    half_v = acc.lane[1] ? word[15:0] : word[31:16];
  end

  // Extract and extend the loaded lane
  always_comb begin
    case (acc.size)
      SZ_WORD: load_v = word;
      SZ_HALF: load_v = {{16{acc.sign_ext & half_v[15]}}, half_v};
      SZ_BYTE: load_v = {{24{acc.sign_ext & byte_v[7]}}, byte_v};
      default: load_v = word;
    endcase
  end

  // Merge store data into the old word
  always_comb begin
    case (acc.size)
      SZ_WORD: begin
        mask = 32'hFFFF_FFFF;
        ins  = store_data;
      end
      SZ_HALF: begin
        mask = 32'h0000_FFFF << sh_h;
        ins  = {16'h0000, store_data[15:0]} << sh_h;
      end
      SZ_BYTE: begin
        mask = 32'h0000_00FF << sh_b;
        ins  = {24'h00_0000, store_data[7:0]} << sh_b;
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        ins  = store_data;
      end
    endcase
    wr_word = (word & ~mask) | (ins & mask);
  end

  // Assemble the result beat
  always_comb begin
    res = '0;
    res.access_error = acc.err;
    if (acc.getc) begin
      res.read_data  = {{24{getc_char[7]}}, getc_char};
      res.getc_taken = 1'b1;
    end else if (acc.rd_out) begin
      res.read_data = load_v;
    end
    if (acc.putc) begin
      res.putc_valid = 1'b1;
      res.putc_char  = store_data[7:0];
    end
  end

endmodule

[hw/rtl/mips_memory_access_unit.sv]
// Memory stage of a small MIPS32 system: code store, data store, getc and putc ports.
// Depends on mmau_pkg, mmau_if, mmau_ram, mmau_wrap, mmau_decode and mmau_exec.
//
// Usage:
//   in_ch carries one access per beat (cmd, address, store_data, getc_char);
//   out_ch returns exactly one result beat per access, in order.
//   Each access runs accept, index reduction, RAM read, then modify/write-back
//   with the result loaded into an output register. The next item is taken
//   only after the previous one is written back; the RAM read is registered
//   and a store is a read-modify-write of the same word. For depths that are
//   not a power of two the index reduction adds a reciprocal multiply, then a
//   multiply-back and subtract.
//   After reset both stores are cleared, one word of each a cycle, during which
//   in_ch.ready stays low.
//   When the receiver stalls, the result holds in the output register; the next
//   item may be accepted and read, and it waits before write-back until the
//   output register is free, so no store commits ahead of its result.
module mips_memory_access_unit #(
  parameter int DATA_WORDS = mmau_pkg::DATA_WORDS_DEF,
  parameter int CODE_WORDS = mmau_pkg::CODE_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mmau_in_if.sink    in_ch,
  mmau_out_if.source out_ch
);
  import mmau_pkg::*;

  localparam int DAW  = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int CAW  = (CODE_WORDS > 1) ? $clog2(CODE_WORDS) : 1;
  localparam int MAXW = (DATA_WORDS > CODE_WORDS) ? DATA_WORDS : CODE_WORDS;
  localparam int CLW  = (MAXW > 1) ? $clog2(MAXW) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CLW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic             clr_last, in_fire, exec_done, idx_done, clearing;

  acc_t             acc_dec, acc_r;
  logic [31:0]      sd_r;
  logic [7:0]       ch_r;

  logic             data_done, code_done;
  logic [DAW-1:0]   data_idx;
  logic [CAW-1:0]   code_idx;

  logic             data_we, code_we, mem_re;
  logic [DAW-1:0]   data_waddr;
  logic [CAW-1:0]   code_waddr;
  logic [31:0]      data_wdata, code_wdata, data_rdata, code_rdata;

  logic [31:0]      old_word, wr_word;
  result_t          res;

  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;

  // Handshake and control strobes
  assign in_ch.ready = state_r == ST_IDLE;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign exec_done   = state_r == ST_EXEC && (!out_valid_r || out_ch.ready);
  assign idx_done    = data_done && code_done;
  assign clearing    = state_r == ST_CLEAR;
  assign clr_last    = clr_cnt_r == CLW'(MAXW - 1);

  // Decode the incoming beat
  mmau_decode u_decode (
    .cmd     (in_ch.cmd),
    .address (in_ch.address),
    .acc     (acc_dec)
  );

  // Reduce word offsets to store indexes
  mmau_wrap #(.MODULUS(DATA_WORDS), .OFS_W(DATA_OFS_W)) u_data_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .ofs   (in_ch.address[DATA_OFS_W+1:2]),
    .done  (data_done),
    .rem   (data_idx)
  );

  mmau_wrap #(.MODULUS(CODE_WORDS), .OFS_W(CODE_OFS_W)) u_code_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .ofs   (in_ch.address[CODE_OFS_W+1:2]),
    .done  (code_done),
    .rem   (code_idx)
  );

  // Memory port muxing: clearing pass or write-back
  always_comb begin
    mem_re = state_r == ST_WAIT && idx_done;
    if (clearing) begin
      data_we    = {1'b0, clr_cnt_r} < (CLW + 1)'(DATA_WORDS);
      code_we    = {1'b0, clr_cnt_r} < (CLW + 1)'(CODE_WORDS);
      data_waddr = clr_cnt_r[DAW-1:0];
      code_waddr = clr_cnt_r[CAW-1:0];
      data_wdata = '0;
      code_wdata = '0;
    end else begin
      data_we    = exec_done && acc_r.data_wr;
      code_we    = exec_done && acc_r.code_wr;
      data_waddr = data_idx;
      code_waddr = code_idx;
      data_wdata = wr_word;
      code_wdata = wr_word;
    end
  end

  mmau_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .re    (mem_re),
    .raddr (data_idx),
    .rdata (data_rdata)
  );

  mmau_ram #(.WIDTH(32), .DEPTH(CODE_WORDS)) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (code_waddr),
    .wdata (code_wdata),
    .re    (mem_re),
    .raddr (code_idx),
    .rdata (code_rdata)
  );

  // Modify the word read back
  assign old_word = acc_r.code_rd ? code_rdata : data_rdata;

  mmau_exec u_exec (
    .acc        (acc_r),
    .word       (old_word),
    .store_data (sd_r),
    .getc_char  (ch_r),
    .res        (res),
    .wr_word    (wr_word)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CLW'(1);
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (idx_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r <= acc_dec;
      sd_r  <= in_ch.store_data;
      ch_r  <= in_ch.getc_char;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_res_r.read_data;
  assign out_ch.access_error = out_res_r.access_error;
  assign out_ch.getc_taken   = out_res_r.getc_taken;
  assign out_ch.putc_valid   = out_res_r.putc_valid;
  assign out_ch.putc_char    = out_res_r.putc_char;

endmodule
